@@ rtl/ecg_channel_preprocess_quality_gate_defines.svh @@
// ----------------------------------------------------------------------------
// ECG preprocess quality gate - assertion macros
// Shared concurrent assertion forms for the block checkers.
// ----------------------------------------------------------------------------
`ifndef ECG_CHANNEL_PREPROCESS_QUALITY_GATE_DEFINES_SVH
`define ECG_CHANNEL_PREPROCESS_QUALITY_GATE_DEFINES_SVH

// same-cycle implication
`define ECGPQG_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ecgpqg check failed");

// next-cycle implication
`define ECGPQG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ecgpqg check failed");

`endif

@@ rtl/ecgpqg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ECG preprocess quality gate - package
// Coefficients, microcode types and the sequencer program.
// ----------------------------------------------------------------------------
package ecgpqg_pkg;

  localparam int SAMPLE_W = 24;
  localparam int QUAL_W   = 23;
  localparam int GAIN_W   = 7;
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 56;
  localparam int QUAL_LSB = 24;
  localparam int GAIN_LSB = 47;
  localparam int STEPS    = 38;

  typedef logic [5:0] step_t;
  localparam step_t LAST_STEP = 6'(STEPS - 1);

  localparam logic [GAIN_W-1:0] GAIN_FULL = 7'd64;

  localparam logic signed [24:0] K_AT  = 25'sd3829822;
  localparam logic signed [24:0] K_BT  = 25'sd364482;
  localparam logic signed [24:0] K_C0  = 25'sd1304282;
  localparam logic signed [24:0] K_C1  = -25'sd1343744;
  localparam logic signed [24:0] K_DD  = 25'sd840167;
  localparam logic signed [24:0] K_A00 = 25'sd6511269;
  localparam logic signed [24:0] K_A01 = -25'sd2513969;
  localparam logic signed [24:0] K_P0  = 25'sd158447;
  localparam logic signed [24:0] K_P1  = 25'sd80779;
  localparam logic signed [24:0] K_PD  = 25'sd4032745;

  localparam logic signed [63:0] RND_HALF = 64'sd2097152;
  localparam logic signed [41:0] S40_MAX  = 42'sd549755813887;
  localparam logic signed [41:0] S40_MIN  = -42'sd549755813888;
  localparam logic signed [41:0] QUAL_MAX = 42'sd8388607;

  localparam logic signed [23:0] CLIP_LOW_RST   = -24'sd65536;
  localparam logic signed [23:0] CLIP_HIGH_RST  = 24'sd65536;
  localparam logic [22:0]        LATCH_LOW_RST  = 23'd6554;
  localparam logic [22:0]        LATCH_HIGH_RST = 23'd45875;

  typedef enum logic [1:0] {
    CFG_CLIP_LOW, CFG_CLIP_HIGH, CFG_LATCH_LOW, CFG_LATCH_HIGH
  } cfg_idx_t;

  typedef enum logic [2:0] {
    A_TREND, A_X, A_S0, A_S1, A_D, A_M, A_PA, A_BP
  } asel_t;

  typedef enum logic [3:0] {
    B_AT, B_BT, B_C0, B_C1, B_DD, B_A00, B_A01, B_P0, B_P1, B_PD, B_GAIN
  } bsel_t;

  typedef enum logic [2:0] {
    ACC_HOLD, ACC_CLR, ACC_ADD, ACC_ADDSH, ACC_RND
  } accop_t;

  typedef enum logic [3:0] {
    WR_NONE, WR_TREND, WR_D, WR_BP, WR_M, WR_BAND, WR_Q, WR_PA, WR_OUT
  } wr_t;

  typedef struct packed {
    logic   mul_en;
    asel_t  a_sel;
    logic   a_hi;
    bsel_t  b_sel;
    accop_t acc_op;
    wr_t    wr;
  } uop_t;

  function automatic int ch_width(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [41:0] v);
    logic signed [39:0] r;
    if (v > S40_MAX) begin
      r = S40_MAX[39:0];
    end else if (v < S40_MIN) begin
      r = S40_MIN[39:0];
    end else begin
      r = v[39:0];
    end
    return r;
  endfunction

  function automatic uop_t mk(input logic mul_en, input asel_t a_sel, input logic a_hi,
                              input bsel_t b_sel, input accop_t acc_op, input wr_t wr);
    uop_t u;
    u.mul_en = mul_en;
    u.a_sel  = a_sel;
    u.a_hi   = a_hi;
    u.b_sel  = b_sel;
    u.acc_op = acc_op;
    u.wr     = wr;
    return u;
  endfunction

  // trend, bandpass, band state, quality, power, gate, output
  function automatic uop_t ucode(input step_t s);
    uop_t u;
    u = mk(1'b0, A_TREND, 1'b0, B_AT, ACC_HOLD, WR_NONE);
    case (s)
      6'd0:  u = mk(1'b1, A_TREND, 1'b0, B_AT,   ACC_CLR,   WR_NONE);
      6'd1:  u = mk(1'b1, A_TREND, 1'b1, B_AT,   ACC_ADD,   WR_NONE);
      6'd2:  u = mk(1'b1, A_X,     1'b0, B_BT,   ACC_ADD,   WR_NONE);
      6'd3:  u = mk(1'b1, A_X,     1'b1, B_BT,   ACC_ADD,   WR_NONE);
      6'd4:  u = mk(1'b0, A_X,     1'b0, B_BT,   ACC_ADD,   WR_NONE);
      6'd5:  u = mk(1'b0, A_X,     1'b0, B_BT,   ACC_RND,   WR_NONE);
      6'd6:  u = mk(1'b1, A_S0,    1'b0, B_C0,   ACC_CLR,   WR_TREND);
      6'd7:  u = mk(1'b1, A_S0,    1'b1, B_C0,   ACC_ADD,   WR_D);
      6'd8:  u = mk(1'b1, A_S1,    1'b0, B_C1,   ACC_ADD,   WR_NONE);
      6'd9:  u = mk(1'b1, A_S1,    1'b1, B_C1,   ACC_ADD,   WR_NONE);
      6'd10: u = mk(1'b1, A_D,     1'b0, B_DD,   ACC_ADD,   WR_NONE);
      6'd11: u = mk(1'b1, A_D,     1'b1, B_DD,   ACC_ADD,   WR_NONE);
      6'd12: u = mk(1'b0, A_D,     1'b0, B_DD,   ACC_ADD,   WR_NONE);
      6'd13: u = mk(1'b0, A_D,     1'b0, B_DD,   ACC_RND,   WR_NONE);
      6'd14: u = mk(1'b1, A_S0,    1'b0, B_A00,  ACC_CLR,   WR_BP);
      6'd15: u = mk(1'b1, A_S0,    1'b1, B_A00,  ACC_ADD,   WR_M);
      6'd16: u = mk(1'b1, A_S1,    1'b0, B_A01,  ACC_ADD,   WR_NONE);
      6'd17: u = mk(1'b1, A_S1,    1'b1, B_A01,  ACC_ADD,   WR_NONE);
      6'd18: u = mk(1'b0, A_D,     1'b0, B_A01,  ACC_ADD,   WR_NONE);
      6'd19: u = mk(1'b0, A_D,     1'b0, B_A01,  ACC_ADDSH, WR_NONE);
      6'd20: u = mk(1'b0, A_D,     1'b0, B_A01,  ACC_RND,   WR_NONE);
      6'd21: u = mk(1'b1, A_PA,    1'b0, B_P0,   ACC_CLR,   WR_BAND);
      6'd22: u = mk(1'b1, A_PA,    1'b1, B_P0,   ACC_ADD,   WR_NONE);
      6'd23: u = mk(1'b1, A_M,     1'b0, B_P1,   ACC_ADD,   WR_NONE);
      6'd24: u = mk(1'b1, A_M,     1'b1, B_P1,   ACC_ADD,   WR_NONE);
      6'd25: u = mk(1'b0, A_M,     1'b0, B_P1,   ACC_ADD,   WR_NONE);
      6'd26: u = mk(1'b0, A_M,     1'b0, B_P1,   ACC_RND,   WR_NONE);
      6'd27: u = mk(1'b1, A_PA,    1'b0, B_PD,   ACC_CLR,   WR_Q);
      6'd28: u = mk(1'b1, A_PA,    1'b1, B_PD,   ACC_ADD,   WR_NONE);
      6'd29: u = mk(1'b0, A_M,     1'b0, B_PD,   ACC_ADD,   WR_NONE);
      6'd30: u = mk(1'b0, A_M,     1'b0, B_PD,   ACC_ADDSH, WR_NONE);
      6'd31: u = mk(1'b0, A_M,     1'b0, B_PD,   ACC_RND,   WR_NONE);
      6'd32: u = mk(1'b0, A_BP,    1'b0, B_GAIN, ACC_HOLD,  WR_PA);
      6'd33: u = mk(1'b1, A_BP,    1'b0, B_GAIN, ACC_CLR,   WR_NONE);
      6'd34: u = mk(1'b1, A_BP,    1'b1, B_GAIN, ACC_ADD,   WR_NONE);
      6'd35: u = mk(1'b0, A_BP,    1'b0, B_GAIN, ACC_ADD,   WR_NONE);
      6'd36: u = mk(1'b0, A_BP,    1'b0, B_GAIN, ACC_RND,   WR_NONE);
      6'd37: u = mk(1'b0, A_BP,    1'b0, B_GAIN, ACC_HOLD,  WR_OUT);
      default: u = mk(1'b0, A_TREND, 1'b0, B_AT, ACC_HOLD, WR_NONE);
    endcase
    return u;
  endfunction

endpackage

@@ rtl/ecg_channel_preprocess_quality_gate.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ECG channel preprocess quality gate
// Per-channel detrend, state-space bandpass, residual quality, hysteresis
// mask and gain ramp, clipped output, on one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
//  group  dir  tdata (low bit up)                  tuser (low bit up)
//  s_*    in   sample[23:0]                        channel
//  m_*    out  filtered, quality, gain, 2'b0 pad   out_channel, mask
//  cfg_*  in   cfg_index 0..3 = clip_low, clip_high, latch_low, latch_high
//
// A sample on a valid channel runs through the sequencer steps on the single
// 21x25 multiplier and the 64-bit accumulator, and no new sample is taken
// until it is through; the block is ready again on the cycle after the last step.
// A sample on a channel at or above CHANNELS is taken and dropped without running the sequencer.
// Reset is synchronous and resets all channel state at once (mask set, gain full).
// A finished word waits in the output register; the next sample proceeds and
// the sequencer holds on its last step until that word is taken.
// ----------------------------------------------------------------------------
module ecg_channel_preprocess_quality_gate #(
  parameter int  CHANNELS = 3,
  localparam int CH_W = ecgpqg_pkg::ch_width(CHANNELS)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [23:0]                       cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [ecgpqg_pkg::S_DATA_W-1:0]   s_tdata,  // sample
  input  logic [CH_W-1:0]                   s_tuser,  // channel
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [ecgpqg_pkg::M_DATA_W-1:0]   m_tdata,  // filtered, quality, gain, pad
  output logic [CH_W:0]                     m_tuser   // out_channel, mask
);

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t                   state;
  ecgpqg_pkg::step_t        step;
  ecgpqg_pkg::uop_t         uop;
  ecgpqg_pkg::wr_t          wr_sel;

  logic [CH_W-1:0]          ch;
  logic signed [23:0]       x;
  logic signed [39:0]       d;
  logic signed [39:0]       bp;
  logic signed [39:0]       m;
  logic [22:0]              q;

  logic signed [39:0]       trend  [CHANNELS];
  logic signed [39:0]       s0     [CHANNELS];
  logic signed [39:0]       s1     [CHANNELS];
  logic signed [39:0]       pa     [CHANNELS];
  logic                     mask_r [CHANNELS];
  logic [6:0]               gain   [CHANNELS];

  logic signed [23:0]       clip_low;
  logic signed [23:0]       clip_high;
  logic [22:0]              latch_low;
  logic [22:0]              latch_high;

  logic signed [45:0]       prod;
  logic                     prod_hi;
  logic signed [63:0]       acc;
  logic signed [63:0]       acc_next;
  logic signed [63:0]       addend;

  logic signed [39:0]       a40;
  logic signed [20:0]       a21;
  logic signed [24:0]       b25;
  logic signed [41:0]       acc_q;
  logic signed [39:0]       rnd40;
  logic signed [41:0]       d_diff;
  logic signed [41:0]       r_diff;
  logic signed [41:0]       r_mag;
  logic [22:0]              q_calc;
  logic signed [39:0]       pa_calc;
  logic                     mask_new;
  logic [6:0]               gain_new;
  logic signed [41:0]       lo42;
  logic signed [41:0]       hi42;
  logic signed [23:0]       y_clip;
  logic                     ch_ok;
  logic                     out_free;
  logic                     run;
  logic                     finish;

  assign s_tready = (state == ST_IDLE);
  assign ch_ok    = (32'(s_tuser) < CHANNELS);
  assign out_free = !m_tvalid || m_tready;
  assign run      = (state == ST_RUN);
  assign finish   = run && (step == ecgpqg_pkg::LAST_STEP) && out_free;
  assign uop      = ecgpqg_pkg::ucode(step);
  assign wr_sel   = run ? uop.wr : ecgpqg_pkg::WR_NONE;

  // operand select
  always_comb begin
    case (uop.a_sel)
      ecgpqg_pkg::A_TREND: a40 = trend[ch];
      ecgpqg_pkg::A_X:     a40 = {{16{x[23]}}, x};
      ecgpqg_pkg::A_S0:    a40 = s0[ch];
      ecgpqg_pkg::A_S1:    a40 = s1[ch];
      ecgpqg_pkg::A_D:     a40 = d;
      ecgpqg_pkg::A_M:     a40 = m;
      ecgpqg_pkg::A_PA:    a40 = pa[ch];
      ecgpqg_pkg::A_BP:    a40 = bp;
      default:             a40 = '0;
    endcase
    case (uop.b_sel)
      ecgpqg_pkg::B_AT:   b25 = ecgpqg_pkg::K_AT;
      ecgpqg_pkg::B_BT:   b25 = ecgpqg_pkg::K_BT;
      ecgpqg_pkg::B_C0:   b25 = ecgpqg_pkg::K_C0;
      ecgpqg_pkg::B_C1:   b25 = ecgpqg_pkg::K_C1;
      ecgpqg_pkg::B_DD:   b25 = ecgpqg_pkg::K_DD;
      ecgpqg_pkg::B_A00:  b25 = ecgpqg_pkg::K_A00;
      ecgpqg_pkg::B_A01:  b25 = ecgpqg_pkg::K_A01;
      ecgpqg_pkg::B_P0:   b25 = ecgpqg_pkg::K_P0;
      ecgpqg_pkg::B_P1:   b25 = ecgpqg_pkg::K_P1;
      ecgpqg_pkg::B_PD:   b25 = ecgpqg_pkg::K_PD;
      ecgpqg_pkg::B_GAIN: b25 = {2'b00, gain[ch], 16'h0000};
      default:            b25 = '0;
    endcase
    a21 = uop.a_hi ? {a40[39], a40[39:20]} : {1'b0, a40[19:0]};
  end

  // accumulator input
  always_comb begin
    case (uop.acc_op)
      ecgpqg_pkg::ACC_ADD: begin
        if (prod_hi) begin
          addend = {prod[43:0], 20'h00000};
        end else begin
          addend = {{18{prod[45]}}, prod};
        end
      end
      ecgpqg_pkg::ACC_ADDSH: addend = {{2{a40[39]}}, a40, 22'h000000};
      ecgpqg_pkg::ACC_RND:
        addend = acc[63] ? (ecgpqg_pkg::RND_HALF - 64'sd1) : ecgpqg_pkg::RND_HALF;
      default: addend = '0;
    endcase
    if (uop.acc_op == ecgpqg_pkg::ACC_CLR) begin
      acc_next = '0;
    end else begin
      acc_next = acc + addend;
    end
  end

  // result shaping
  always_comb begin
    acc_q  = acc[63:22];
    rnd40  = ecgpqg_pkg::sat40(acc_q);
    d_diff = {{18{x[23]}}, x} - {{2{trend[ch][39]}}, trend[ch]};
    r_diff = {{2{d[39]}}, d} - {{2{bp[39]}}, bp};
    r_mag  = r_diff[41] ? -r_diff : r_diff;

    if (acc_q < 42'sd0) begin
      q_calc = '0;
    end else if (acc_q > ecgpqg_pkg::QUAL_MAX) begin
      q_calc = ecgpqg_pkg::QUAL_MAX[22:0];
    end else begin
      q_calc = acc_q[22:0];
    end

    if (acc_q < 42'sd0) begin
      pa_calc = '0;
    end else if (acc_q > ecgpqg_pkg::S40_MAX) begin
      pa_calc = ecgpqg_pkg::S40_MAX[39:0];
    end else begin
      pa_calc = acc_q[39:0];
    end

    if (q < latch_low) begin
      mask_new = 1'b1;
    end else if (q >= latch_high || !mask_r[ch]) begin
      mask_new = 1'b0;
    end else begin
      mask_new = 1'b1;
    end

    gain_new = gain[ch];
    if (mask_new) begin
      if (gain[ch] < ecgpqg_pkg::GAIN_FULL) begin
        gain_new = gain[ch] + 7'd1;
      end
    end else if (gain[ch] != 7'd0) begin
      gain_new = gain[ch] - 7'd1;
    end

    lo42 = {{18{clip_low[23]}}, clip_low};
    hi42 = {{18{clip_high[23]}}, clip_high};
    if (acc_q < lo42) begin
      y_clip = clip_low;
    end else if (acc_q > hi42) begin
      y_clip = clip_high;
    end else begin
      y_clip = acc_q[23:0];
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid && ch_ok) begin
            state <= ST_RUN;
            step  <= '0;
          end
        end
        ST_RUN: begin
          if (step == ecgpqg_pkg::LAST_STEP) begin
            if (out_free) begin
              m_tdata  <= {2'b00, gain[ch], q, y_clip};
              m_tuser  <= {mask_r[ch], ch};
              state    <= ST_IDLE;
            end
          end else begin
            step <= step + 6'd1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // shared multiply-accumulate
  always_ff @(posedge clk) begin
    if (run && uop.mul_en) begin
      prod    <= a21 * b25;
      prod_hi <= uop.a_hi;
    end
    if (run) begin
      acc <= acc_next;
    end
    if (s_tvalid && s_tready) begin
      ch <= s_tuser;
      x  <= s_tdata[23:0];
    end
    case (wr_sel)
      ecgpqg_pkg::WR_D:  d  <= ecgpqg_pkg::sat40(d_diff);
      ecgpqg_pkg::WR_BP: bp <= rnd40;
      ecgpqg_pkg::WR_M:  m  <= ecgpqg_pkg::sat40(r_mag);
      ecgpqg_pkg::WR_Q:  q  <= q_calc;
      default: ;
    endcase
  end

  // channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        trend[i]  <= '0;
        s0[i]     <= '0;
        s1[i]     <= '0;
        pa[i]     <= '0;
        mask_r[i] <= 1'b1;
        gain[i]   <= ecgpqg_pkg::GAIN_FULL;
      end
    end else begin
      case (wr_sel)
        ecgpqg_pkg::WR_TREND: trend[ch] <= rnd40;
        ecgpqg_pkg::WR_BAND: begin
          s0[ch] <= rnd40;
          s1[ch] <= s0[ch];
        end
        ecgpqg_pkg::WR_PA: begin
          pa[ch]     <= pa_calc;
          mask_r[ch] <= mask_new;
          gain[ch]   <= gain_new;
        end
        default: ;
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clip_low   <= ecgpqg_pkg::CLIP_LOW_RST;
      clip_high  <= ecgpqg_pkg::CLIP_HIGH_RST;
      latch_low  <= ecgpqg_pkg::LATCH_LOW_RST;
      latch_high <= ecgpqg_pkg::LATCH_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ecgpqg_pkg::CFG_CLIP_LOW:   clip_low   <= cfg_data;
        ecgpqg_pkg::CFG_CLIP_HIGH:  clip_high  <= cfg_data;
        ecgpqg_pkg::CFG_LATCH_LOW:  latch_low  <= cfg_data[22:0];
        ecgpqg_pkg::CFG_LATCH_HIGH: latch_high <= cfg_data[22:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/ecgpqg_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ECG preprocess quality gate - port checker
// Port-level checks on sample intake, word timing and gate output.
// ----------------------------------------------------------------------------
`include "ecg_channel_preprocess_quality_gate_defines.svh"

module ecgpqg_chk #(
  parameter int  CHANNELS = 3,
  localparam int CH_W = ecgpqg_pkg::ch_width(CHANNELS)
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [CH_W-1:0]                 s_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [ecgpqg_pkg::M_DATA_W-1:0] m_tdata,
  input logic [CH_W:0]                   m_tuser
);

  logic take_ok;
  logic take_bad;
  logic gain_zero;

  assign take_ok   = s_tvalid && s_tready && (32'(s_tuser) < CHANNELS);
  assign take_bad  = s_tvalid && s_tready && (32'(s_tuser) >= CHANNELS);
  assign gain_zero = (m_tdata[ecgpqg_pkg::GAIN_LSB +: ecgpqg_pkg::GAIN_W] == 7'd0);

  `ECGPQG_ASSERT_NEXT(a_busy_after_take, clk, rst, take_ok, !s_tready)
  `ECGPQG_ASSERT_NEXT(a_drop_stays_ready, clk, rst, take_bad, s_tready)
  `ECGPQG_ASSERT_NOW(a_word_after_run, clk, rst, $rose(m_tvalid), $past(!s_tready))
  `ECGPQG_ASSERT_NOW(a_mask_has_gain, clk, rst, m_tvalid && m_tuser[CH_W], !gain_zero)
  `ECGPQG_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, $stable(m_tdata))

endmodule

bind ecg_channel_preprocess_quality_gate ecgpqg_chk #(.CHANNELS(CHANNELS)) u_chk (.*);
